// ===== rtl/sorted_set_insert_delete_defines.svh =====
// Assertion macros used by the sorted set back end (ssi_back)
`ifndef SORTED_SET_INSERT_DELETE_DEFINES_SVH
`define SORTED_SET_INSERT_DELETE_DEFINES_SVH

`ifndef SYNTHESIS
`define SSI_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sorted set assertion failed");
`define SSI_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("sorted set forbidden condition");
`else
`define SSI_ASSERT(lbl, clk, rst_n, prop)
`define SSI_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ===== rtl/ssi_pkg.sv =====
// Shared types and constants of the sorted set block
package ssi_pkg;

    localparam int DATA_W       = 32;
    localparam int CAPACITY_DEF = 32;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_DUP      = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        t_op                      op;
        logic signed [DATA_W-1:0] value;
    } t_cmd;

endpackage

// ===== rtl/sorted_set_insert_delete.sv =====
// Each command moves from the queue through S_IDLE capture, S_CMP compare and S_UPD update
// into S_LIST, which loads the output register; the next is taken once the listing ends.
// Listing sends one element a cycle off the rotating cell row while i_ready allows it.
// A two-entry command queue keeps accepting while the cell row works, until it is full.
// Reset clears the set count, the queue and all handshake state; cell contents are kept.
module sorted_set_insert_delete
    import ssi_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_mode,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [DATA_W-1:0] o_element,
    output logic                     o_last,
    output logic                     o_empty_res,
    output logic [1:0]               o_status
);

    logic w_cmd_valid;
    logic w_cmd_ready;
    t_cmd w_cmd;

    ssi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_mode      (i_mode),
        .i_value     (i_value),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_ready (w_cmd_ready)
    );

    ssi_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_ready (w_cmd_ready),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_element   (o_element),
        .o_last      (o_last),
        .o_empty_res (o_empty_res),
        .o_status    (o_status)
    );

endmodule

// ===== rtl/ssi_front.sv =====
// Input side: accept transfers, decode the operation, queue commands
module ssi_front
    import ssi_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_mode,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_cmd_valid,
    output t_cmd                     o_cmd,
    input  logic                     i_cmd_ready
);

    t_cmd       r_queue [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;
    logic       n_push;
    logic       n_pop;
    t_cmd       n_cmd;

    assign o_ready     = (r_fill != 2'd2);
    assign o_cmd_valid = (r_fill != 2'd0);
    assign o_cmd       = r_queue[r_rd_ptr];

    assign n_push = i_valid && o_ready;
    assign n_pop  = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_cmd.op    = (i_mode == 1'b1) ? OP_DELETE : OP_INSERT;
        n_cmd.value = i_value;
    end

    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_queue[r_wr_ptr] <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (n_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (n_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({n_push, n_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

// ===== rtl/ssi_back.sv =====
// Execution side: sorted cell row, update sequencer and result register
`include "sorted_set_insert_delete_defines.svh"
module ssi_back
    import ssi_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cmd_valid,
    input  t_cmd                     i_cmd,
    output logic                     o_cmd_ready,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [DATA_W-1:0] o_element,
    output logic                     o_last,
    output logic                     o_empty_res,
    output logic [1:0]               o_status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_UPD  = 4'b0100,
        S_LIST = 4'b1000
    } t_state;

    t_state                    r_state, n_state;
    logic signed [DATA_W-1:0]  r_ent [CAPACITY];
    logic signed [DATA_W-1:0]  n_ent [CAPACITY];
    logic                      n_ent_we;
    logic [CNT_W-1:0]          r_count, n_count;
    t_cmd                      r_cmd;
    logic [CAPACITY-1:0]       r_lt, r_eq;
    logic [CAPACITY-1:0]       n_lt, n_eq;
    t_status                   r_status, n_status;
    logic [IDX_W-1:0]          r_idx, n_idx;
    logic                      r_out_valid;
    logic signed [DATA_W-1:0]  r_out_elem;
    logic                      r_out_last;
    logic                      r_out_empty;
    t_status                   r_out_status;
    logic                      n_load;
    logic                      n_found;
    logic                      n_full;
    logic                      n_last;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_element   = r_out_elem;
    assign o_last      = r_out_last;
    assign o_empty_res = r_out_empty;
    assign o_status    = r_out_status;

    assign n_found = |r_eq;
    assign n_full  = (r_count == CNT_W'(CAPACITY));
    assign n_last  = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);
    assign n_load  = (r_state == S_LIST) && (!r_out_valid || i_ready);

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_lt[i] = (CNT_W'(i) < r_count) && (r_ent[i] < r_cmd.value);
            n_eq[i] = (CNT_W'(i) < r_count) && (r_ent[i] == r_cmd.value);
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_status = r_status;
        n_idx    = r_idx;
        n_ent_we = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            n_ent[i] = r_ent[i];
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                n_state = S_LIST;
                n_idx   = '0;
                if (r_cmd.op == OP_INSERT) begin
                    if (n_found) begin
                        n_status = ST_DUP;
                    end else if (n_full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_status = ST_DONE;
                        n_count  = r_count + CNT_W'(1);
                        n_ent_we = 1'b1;
                        n_ent[0] = r_lt[0] ? r_ent[0] : r_cmd.value;
                        for (int i = 1; i < CAPACITY; i++) begin
                            n_ent[i] = r_lt[i]   ? r_ent[i] :
                                       r_lt[i-1] ? r_cmd.value : r_ent[i-1];
                        end
                    end
                end else begin
                    if (!n_found) begin
                        n_status = ST_NOTFOUND;
                    end else begin
                        n_status = ST_DONE;
                        n_count  = r_count - CNT_W'(1);
                        n_ent_we = 1'b1;
                        for (int i = 0; i < CAPACITY - 1; i++) begin
                            n_ent[i] = r_lt[i] ? r_ent[i] : r_ent[i+1];
                        end
                    end
                end
            end
            S_LIST: begin
                if (n_load) begin
                    if (r_count == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        // rotate the occupied cells so the next element sits at the head
                        n_ent_we = 1'b1;
                        for (int i = 0; i < CAPACITY; i++) begin
                            if ((CNT_W'(i) + CNT_W'(1)) == r_count) begin
                                n_ent[i] = r_ent[0];
                            end else if (i < CAPACITY - 1) begin
                                n_ent[i] = r_ent[(i + 1) % CAPACITY];
                            end
                        end
                        if (n_last) begin
                            n_state = S_IDLE;
                            n_idx   = '0;
                        end else begin
                            n_idx = r_idx + IDX_W'(1);
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (n_ent_we) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_ent[i] <= n_ent[i];
            end
        end
        if (r_state == S_IDLE && i_cmd_valid) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_CMP) begin
            r_lt <= n_lt;
            r_eq <= n_eq;
        end
        if (n_load) begin
            r_out_status <= r_status;
            if (r_count == '0) begin
                r_out_elem  <= '0;
                r_out_last  <= 1'b1;
                r_out_empty <= 1'b1;
            end else begin
                r_out_elem  <= r_ent[0];
                r_out_last  <= n_last;
                r_out_empty <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_status    <= ST_DONE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_status <= n_status;
            r_idx    <= n_idx;
            if (n_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `SSI_NEVER(a_count_bound, i_clk, i_rst_n, r_count > CNT_W'(CAPACITY))
    `SSI_ASSERT(a_empty_form, i_clk, i_rst_n, (o_valid && o_empty_res) |-> (o_last && o_element == '0))
    `SSI_ASSERT(a_list_ends, i_clk, i_rst_n, (n_load && (n_last || r_count == '0)) |=> (r_state == S_IDLE))
    `SSI_ASSERT(a_count_step, i_clk, i_rst_n, (r_state != S_UPD) |=> $stable(r_count))

endmodule
